// ===== rtl/core/gamma_log_binary_search_defines.svh =====
// Assertion macros shared by the gamma correction RTL.
`ifndef GAMMA_LOG_BINARY_SEARCH_DEFINES_SVH
`define GAMMA_LOG_BINARY_SEARCH_DEFINES_SVH

// same-cycle implication, checked out of reset
`define GLS_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define GLS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/gls_pkg.sv =====
// Constants and elaboration-time log functions for the gamma correction block.
package gls_pkg;

    localparam int PIX_W      = 8;
    localparam int GAMMA_W    = 24;
    localparam int GAMMA_FRAC = 16;
    localparam int INT_FRAC   = 58;
    localparam int MAG_INT_W  = 4;     // ln(65535) < 16
    localparam logic [63:0] LN2_Q64 = 64'hB17217F7D1CF79AC;

    // ln(n), n >= 1, unsigned with INT_FRAC fraction bits; elaboration only
    function automatic logic [63:0] ln_q58(input logic [63:0] n);
        int unsigned k;
        logic [63:0]  y;
        logic [63:0]  frac;
        logic [127:0] p;
        k    = 0;
        frac = '0;
        while (k < 40 && (n >> (k + 1)) != 64'd0)
            k++;
        y = n << (62 - k);
        for (int i = 1; i <= INT_FRAC; i++)
        begin
            p = {64'd0, y} * {64'd0, y};
            y = p[125:62];
            if (y[63])
            begin
                frac = frac | (64'd1 << (INT_FRAC - i));
                y    = y >> 1;
            end
        end
        p = {64'd0, ((64'(k) << INT_FRAC) | frac)} * {64'd0, LN2_Q64};
        return p[127:64];
    endfunction

    // |ln(m/full)| rounded to frac_bits fraction bits
    function automatic logic [63:0] log_mag(input logic [63:0] m,
                                            input logic [63:0] ln_full,
                                            input int unsigned frac_bits);
        logic [63:0] lm;
        logic [63:0] u;
        int unsigned s;
        lm = ln_q58(m);
        u  = (ln_full > lm) ? ln_full - lm : 64'd0;
        s  = INT_FRAC - frac_bits;
        return (u + (64'd1 << (s - 1))) >> s;
    endfunction

endpackage

// ===== rtl/core/gls_log_rom.sv =====
// Constant ROM of |ln(m/PIXEL_MAX)| with a registered read port.
module gls_log_rom
    import gls_pkg::*;
#(
    parameter int PIXEL_MAX     = 255,
    parameter int LOG_FRAC_BITS = 24,
    parameter int IDX_W         = 8,
    parameter int MAG_W         = 28
)
(
    input  logic             clk,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] addr,
    output logic [MAG_W-1:0] data
);

    localparam logic [63:0] LN_FULL = ln_q58(64'(PIXEL_MAX));

    logic [MAG_W-1:0] rom [PIXEL_MAX+1];
    logic [MAG_W-1:0] data_reg;

    // entry 0 stands for minus infinity and is never probed
    assign rom[0] = '0;

    for (genvar g = 1; g <= PIXEL_MAX; g++)
    begin : g_entry
        localparam logic [63:0] ENTRY = log_mag(64'(g), LN_FULL, LOG_FRAC_BITS);
        assign rom[g] = ENTRY[MAG_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            data_reg <= rom[addr];
    end

    assign data = data_reg;

endmodule

// ===== rtl/core/gamma_log_binary_search.sv =====
// Gamma correction by log-domain multiply and binary search of a log ROM.
//
// Channels: pixel_in arrives on in_valid/in_ready, pixel_out leaves on
// out_valid/out_ready, and gamma_q8_16 (unsigned Q8.16) is written on
// cfg_valid/cfg_ready, always ready. Write gamma only while the block is idle.
// One word is processed at a time; in_ready is high only when the sequencer
// is idle. For a nonzero word the log entry is read as the word is accepted,
// the shared 8-bit-slice multiplier forms gamma*|ln(x)| slice by slice, each
// search probe is a ROM read, then a compare, over at most
// ceil(log2(PIXEL_MAX+1)) probes, and the output register is then loaded.
// A zero word skips the multiply and the search and goes straight to the
// output register.
// The result sits in an output register; the sequencer holds it in its last
// state while a previous result still waits for out_ready.
// Reset clears the sequencer and the output valid and sets gamma to 1.0.
module gamma_log_binary_search
    import gls_pkg::*;
#(
    parameter int PIXEL_MAX     = 255,
    parameter int LOG_FRAC_BITS = 24
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [PIX_W-1:0]   pixel_in,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [PIX_W-1:0]   pixel_out,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [GAMMA_W-1:0] gamma_q8_16
);

`include "gamma_log_binary_search_defines.svh"

    localparam int IDX_W  = $clog2(PIXEL_MAX + 1);
    localparam int MAG_W  = LOG_FRAC_BITS + MAG_INT_W;
    localparam int PROD_W = MAG_W + GAMMA_W;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_RD   = 3'd2;
    localparam logic [2:0] ST_CMP  = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [2:0]         state_reg, state_next;
    logic [GAMMA_W-1:0] gamma_reg;
    logic [IDX_W-1:0]   lo_reg, lo_next;
    logic [IDX_W-1:0]   hi_reg, hi_next;
    logic [IDX_W-1:0]   mid_reg, mid_next;
    logic [1:0]         mcnt_reg, mcnt_next;
    logic [PROD_W-1:0]  acc_reg, acc_next;
    logic               out_valid_reg;
    logic [PIX_W-1:0]   pixel_out_reg;

    logic               rom_rd;
    logic [IDX_W-1:0]   rom_addr;
    logic [MAG_W-1:0]   rom_data;
    logic [31:0]        x_ext;
    logic [IDX_W-1:0]   x_clamp;
    logic [IDX_W:0]     mid_sum;
    logic [MAG_W+7:0]   partial;
    logic [PROD_W-1:0]  scaled;
    logic               probe_ok;
    logic [31:0]        lo_ext;
    logic               out_load;

    gls_log_rom #(
        .PIXEL_MAX     (PIXEL_MAX),
        .LOG_FRAC_BITS (LOG_FRAC_BITS),
        .IDX_W         (IDX_W),
        .MAG_W         (MAG_W)
    ) u_rom (
        .clk   (clk),
        .rd_en (rom_rd),
        .addr  (rom_addr),
        .data  (rom_data)
    );

    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;

    assign x_ext   = {{(32-PIX_W){1'b0}}, pixel_in};
    assign x_clamp = (x_ext > 32'(PIXEL_MAX)) ? IDX_W'(PIXEL_MAX) : x_ext[IDX_W-1:0];
    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg} + {{IDX_W{1'b0}}, 1'b1};

    // one 8-bit slice of gamma per cycle through the shared multiplier
    assign partial  = rom_data * gamma_reg[8*mcnt_reg +: 8];
    assign scaled   = {rom_data, {GAMMA_FRAC{1'b0}}, {(PROD_W-MAG_W-GAMMA_FRAC){1'b0}}}
                      >> (GAMMA_W - GAMMA_FRAC);
    assign probe_ok = (scaled >= acc_reg);

    assign lo_ext   = {{(32-IDX_W){1'b0}}, lo_reg};
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        mid_next   = mid_reg;
        mcnt_next  = mcnt_reg;
        acc_next   = acc_reg;
        rom_rd     = 1'b0;
        rom_addr   = x_clamp;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    lo_next   = '0;
                    mcnt_next = '0;
                    acc_next  = '0;
                    if (pixel_in == '0)
                    begin
                        hi_next    = '0;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        hi_next    = IDX_W'(PIXEL_MAX);
                        rom_rd     = 1'b1;
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL:
            begin
                acc_next  = acc_reg + (PROD_W'(partial) << (8 * mcnt_reg));
                mcnt_next = mcnt_reg + 2'd1;
                if (mcnt_reg == 2'd2)
                    state_next = ST_RD;
            end
            ST_RD:
            begin
                mid_next   = mid_sum[IDX_W:1];
                rom_addr   = mid_sum[IDX_W:1];
                rom_rd     = 1'b1;
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (probe_ok)
                    lo_next = mid_reg;
                else
                    hi_next = mid_reg - IDX_W'(1);
                state_next = (lo_next == hi_next) ? ST_DONE : ST_RD;
            end
            ST_DONE:
            begin
                if (out_load)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            gamma_reg     <= GAMMA_W'(65536);
            lo_reg        <= '0;
            hi_reg        <= '0;
            mcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            lo_reg    <= lo_next;
            hi_reg    <= hi_next;
            mcnt_reg  <= mcnt_next;
            if (cfg_valid)
                gamma_reg <= gamma_q8_16;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        mid_reg <= mid_next;
        acc_reg <= acc_next;
        if (out_load)
            pixel_out_reg <= (lo_ext > 32'd255) ? 8'hFF : lo_ext[PIX_W-1:0];
    end

    assign out_valid = out_valid_reg;
    assign pixel_out = pixel_out_reg;

    `GLS_ASSERT_IMPL(a_bounds_ordered, state_reg != ST_IDLE, lo_reg <= hi_reg,
        "search bounds crossed")
    `GLS_ASSERT_IMPL(a_done_converged, state_reg == ST_DONE, lo_reg == hi_reg,
        "search ended without converging")
    `GLS_ASSERT_IMPL(a_mul_count, state_reg == ST_MUL, mcnt_reg <= 2'd2,
        "multiplier slice count out of range")
    `GLS_ASSERT_NEXT(a_zero_shortcut, in_valid && in_ready && pixel_in == '0,
        state_reg == ST_DONE && hi_reg == '0, "zero word did not short-cut")

endmodule
